>>> src/vector_window_average_macros.svh
// ---------------------------------------------------------------------------
// vector_window_average_macros
// Assertion macros shared by the window average block.
// ---------------------------------------------------------------------------
`ifndef VECTOR_WINDOW_AVERAGE_MACROS_SVH
`define VECTOR_WINDOW_AVERAGE_MACROS_SVH

// Antecedent holds in a cycle: consequent holds in the same cycle.
`define VWA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle: consequent holds in the next cycle.
`define VWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/vwa_pkg.sv
// ---------------------------------------------------------------------------
// vwa_pkg
// Types and fixed widths shared by the window average modules.
// ---------------------------------------------------------------------------
package vwa_pkg;

	localparam int FIELD_W   = 32;
	localparam int COUNT_W   = 9;
	localparam int MAX_LANES = 4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // take the input vector, read the oldest ring slot
		logic update;    // update running sums, write the ring, advance slot
		logic div_load;  // load the dividers
		logic div_step;  // one quotient bit per lane
		logic out_load;  // move quotients into the output register
	} vwa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register empty or being taken this cycle
	} vwa_status_t;

endpackage

>>> src/vwa_div_lane.sv
// ---------------------------------------------------------------------------
// vwa_div_lane
// Bit-serial restoring divider for one lane: signed sum by unsigned count,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
module vwa_div_lane #(
	parameter int MW = 41,
	parameter int CW = 9
) (
	input  logic                            clk,
	input  logic                            load,
	input  logic                            step,
	input  logic [MW-1:0]                   dividend,
	input  logic [CW-1:0]                   divisor,
	output logic [vwa_pkg::FIELD_W-1:0]     quotient
);
	import vwa_pkg::*;

	logic          neg_q;
	logic [MW-1:0] acc_q;
	logic [CW:0]   rem_q;
	logic [CW-1:0] dvs_q;
	logic [CW:0]   trial;
	logic          fits;
	logic [FIELD_W-1:0] mag;

	assign trial = {rem_q[CW-1:0], acc_q[MW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign mag   = acc_q[FIELD_W-1:0];
	assign quotient = neg_q ? (~mag + FIELD_W'(1)) : mag;

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= dividend[MW-1];
			acc_q <= dividend[MW-1] ? (~dividend + MW'(1)) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			if (fits) begin
				rem_q <= trial - {1'b0, dvs_q};
				acc_q <= {acc_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				acc_q <= {acc_q[MW-2:0], 1'b0};
			end
		end
	end

endmodule

>>> src/vwa_datapath.sv
// ---------------------------------------------------------------------------
// vwa_datapath
// Ring memory, running lane sums, slot and fill counters, per-lane dividers
// and the output register.
// ---------------------------------------------------------------------------
module vwa_datapath #(
	parameter int WINDOW = 500,
	parameter int LANES  = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  vwa_pkg::vwa_cmd_t                      cmd,
	output vwa_pkg::vwa_status_t                   status,
	input  logic [LANES-1:0][vwa_pkg::FIELD_W-1:0] delta,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic [LANES-1:0][vwa_pkg::FIELD_W-1:0] mean,
	output logic [vwa_pkg::COUNT_W-1:0]            fill_count
);
	import vwa_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int SW = FIELD_W + $clog2(WINDOW);
	localparam int RW = LANES * FIELD_W;

	logic [RW-1:0]          ring_mem [WINDOW];
	logic [RW-1:0]          rdata_q;
	logic [RW-1:0]          vec_q;
	logic [AW-1:0]          slot_q;
	logic [CW-1:0]          count_q;
	logic [SW-1:0]          sum_q [LANES];
	logic                   full;
	logic [LANES-1:0][FIELD_W-1:0] quot;
	logic [LANES-1:0][FIELD_W-1:0] mean_q;
	logic [COUNT_W-1:0]     fill_q;
	logic                   out_valid_q;

	assign full = count_q == CW'(WINDOW);

	// Ring: read the oldest slot on capture, overwrite it on update.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rdata_q <= ring_mem[slot_q];
			vec_q   <= delta;
		end
		if (cmd.update) begin
			ring_mem[slot_q] <= vec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			for (int l = 0; l < LANES; l++) begin
				sum_q[l] <= '0;
			end
		end else if (cmd.update) begin
			slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + AW'(1);
			if (!full) begin
				count_q <= count_q + CW'(1);
			end
			for (int l = 0; l < LANES; l++) begin
				sum_q[l] <= sum_q[l]
					- (full ? {{(SW-FIELD_W){rdata_q[l*FIELD_W+FIELD_W-1]}},
					           rdata_q[l*FIELD_W +: FIELD_W]} : SW'(0))
					+ {{(SW-FIELD_W){vec_q[l*FIELD_W+FIELD_W-1]}},
					   vec_q[l*FIELD_W +: FIELD_W]};
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_div
		vwa_div_lane #(
			.MW (SW),
			.CW (CW)
		) u_div (
			.clk      (clk),
			.load     (cmd.div_load),
			.step     (cmd.div_step),
			.dividend (sum_q[l]),
			.divisor  (count_q),
			.quotient (quot[l])
		);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q <= quot;
			fill_q <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.out_load | (out_valid_q & out_stall);
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign mean       = mean_q;
	assign fill_count = fill_q;

endmodule

>>> src/vwa_ctrl.sv
// ---------------------------------------------------------------------------
// vwa_ctrl
// Sequencer for one item: capture, sum update, divider load, bit-serial
// divide, hand-off to the output register.
// ---------------------------------------------------------------------------
module vwa_ctrl #(
	parameter int MW = 41
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  vwa_pkg::vwa_status_t status,
	output vwa_pkg::vwa_cmd_t    cmd
);
	import vwa_pkg::*;

	localparam int BW = $clog2(MW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [BW-1:0] bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					bit_q   <= BW'(MW - 1);
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register can take the result
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = state_q != ST_IDLE;
	assign cmd.capture  = (state_q == ST_IDLE) && in_valid;
	assign cmd.update   = state_q == ST_UPDATE;
	assign cmd.div_load = state_q == ST_LOAD;
	assign cmd.div_step = state_q == ST_DIVIDE;
	assign cmd.out_load = (state_q == ST_FINISH) && status.out_free;

endmodule

>>> src/vector_window_average.sv
// ---------------------------------------------------------------------------
// vector_window_average
// Sliding-window mean of a stream of four-lane Q16.16 delta vectors.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries delta_a..delta_d; a transfer
//   happens on a clock edge with in_valid high and in_stall low. Output
//   channel out_valid/out_stall carries mean_a..mean_d and fill_count, one
//   result per input transfer, in order.
//   Each vector goes into a ring of the last WINDOW vectors; running lane
//   sums add the new value and, once the ring is full, drop the oldest one.
//   Means are sum / fill_count, truncated toward zero, from one bit-serial
//   divider per lane at one quotient bit a cycle.
//   After an input transfer the controller updates the sums, loads the
//   dividers, runs the bit loop over the MW-bit sums, MW = 32 + clog2(WINDOW)
//   (41 by default), and then loads the output register. One item is in
//   work at a time: a new transfer is taken only once that item has moved on.
//   The output register parts the two sides: the next vector is taken while
//   a result waits. A stalled result holds; the finished item after it waits
//   in the controller and in_stall stays high until the output frees.
//   Reset clears sums, slot and fill count; ring contents are left as they
//   are and are only used after being written. Lanes at or above LANES
//   ignore their input and give zero means.
// ---------------------------------------------------------------------------
`include "vector_window_average_macros.svh"

module vector_window_average #(
	parameter int WINDOW = 500,
	parameter int LANES  = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [vwa_pkg::FIELD_W-1:0] delta_a,
	input  logic signed [vwa_pkg::FIELD_W-1:0] delta_b,
	input  logic signed [vwa_pkg::FIELD_W-1:0] delta_c,
	input  logic signed [vwa_pkg::FIELD_W-1:0] delta_d,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [vwa_pkg::FIELD_W-1:0] mean_a,
	output logic signed [vwa_pkg::FIELD_W-1:0] mean_b,
	output logic signed [vwa_pkg::FIELD_W-1:0] mean_c,
	output logic signed [vwa_pkg::FIELD_W-1:0] mean_d,
	output logic        [vwa_pkg::COUNT_W-1:0] fill_count
);
	import vwa_pkg::*;

	localparam int MW = FIELD_W + $clog2(WINDOW);

	vwa_cmd_t    cmd;
	vwa_status_t status;

	logic [MAX_LANES-1:0][FIELD_W-1:0] delta_all;
	logic [MAX_LANES-1:0][FIELD_W-1:0] mean_all;
	logic [LANES-1:0][FIELD_W-1:0]     delta_used;
	logic [LANES-1:0][FIELD_W-1:0]     mean_used;

	assign delta_all = {delta_d, delta_c, delta_b, delta_a};

	for (genvar l = 0; l < MAX_LANES; l++) begin : g_lane
		if (l < LANES) begin : g_used
			assign delta_used[l] = delta_all[l];
			assign mean_all[l]   = mean_used[l];
		end else begin : g_unused
			assign mean_all[l] = '0;
		end
	end

	assign mean_a = mean_all[0];
	assign mean_b = mean_all[1];
	assign mean_c = mean_all[2];
	assign mean_d = mean_all[3];

	vwa_ctrl #(
		.MW (MW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	vwa_datapath #(
		.WINDOW (WINDOW),
		.LANES  (LANES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.delta      (delta_used),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.mean       (mean_used),
		.fill_count (fill_count)
	);

	`VWA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken mid-work")
	`VWA_ASSERT_SAME(a_out_free, cmd.out_load, status.out_free, "result loaded over a held one")
	`VWA_ASSERT_NEXT(a_div_start, cmd.div_load, cmd.div_step, "divider loaded but not stepped")

endmodule
